### hw/rtl/ebr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebr_pkg - shared types and constants of the Exp-Golomb bitstream reader
// Command and result words, operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package ebr_pkg;

	localparam int BUFFER_BYTES_DEF  = 4096;
	localparam int MAX_READ_BITS_DEF = 32;

	localparam int FILL_MAX = 8191;
	localparam logic [15:0] POS_MAX = 16'hFFFF;

	// operation codes
	localparam logic [3:0] OP_RESTART = 4'd0;
	localparam logic [3:0] OP_LOAD    = 4'd1;
	localparam logic [3:0] OP_PEEK    = 4'd2;
	localparam logic [3:0] OP_READ    = 4'd3;
	localparam logic [3:0] OP_UE      = 4'd4;
	localparam logic [3:0] OP_SE      = 4'd5;
	localparam logic [3:0] OP_TE      = 4'd6;
	localparam logic [3:0] OP_ALIGN   = 4'd7;
	localparam logic [3:0] OP_FIND    = 4'd8;
	localparam logic [3:0] OP_POS     = 4'd9;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_GOLOMB    = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [7:0] BYTE_00 = 8'h00;
	localparam logic [7:0] BYTE_01 = 8'h01;
	localparam logic [7:0] BYTE_7F = 8'h7F;

	typedef struct packed {
		logic [3:0] operation;
		logic [7:0] data_byte;
		logic [5:0] bit_count;
	} cmd_t;

	typedef struct packed {
		logic signed [32:0] value;
		logic [1:0]         status;
		logic [2:0]         start_code_length;
		logic [12:0]        byte_position;
		logic [2:0]         bit_in_byte;
	} rsp_t;

	// bit lookup result from the buffer unit
	typedef struct packed {
		logic present;
		logic bit_val;
	} bit_t;

endpackage

### hw/rtl/bitstream_reader_exp_golomb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitstream_reader_exp_golomb - command-driven MSB-first bit reader
// Fixed reads, ue/se/te Exp-Golomb, align, start-code search and position
// query over a byte buffer, stepped one bit per cycle between byte fetches by a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | ports               | handshake
//  ---------+---------------------+--------------------------------------
//  command  | start, busy, cmd    | word taken when start && !busy
//  result   | done, rsp           | word valid for the single done cycle
//
// Restart, load, position query and unaligned align never raise busy; their
// result word, if any, shows in the next cycle.
// Bit commands hold busy through a fetch step for each byte the bit index
// enters (the first one included, and the next byte when the last bit ends
// a byte), a step per bit and the closing steps; done
// follows as busy drops. A start-code search repeats that per byte examined.
// The single bit lookup on the buffer port sets the rate.
// No clearing pass after reset: only bytes below the fill are ever used.
// The receiver cannot stall; busy is the only back-pressure.
// ----------------------------------------------------------------------------
module bitstream_reader_exp_golomb import ebr_pkg::*; #(
	parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF,
	parameter int MAX_READ_BITS = MAX_READ_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	localparam int FILL_LIMIT = (BUFFER_BYTES < FILL_MAX) ? BUFFER_BYTES : FILL_MAX;
	localparam logic [6:0] MAXB = 7'(MAX_READ_BITS);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FETCH = 2'd1;
	localparam logic [1:0] S_BIT   = 2'd2;
	localparam logic [1:0] S_POST  = 2'd3;

	logic [1:0]  state_q;
	logic [3:0]  op_q;
	logic [12:0] fill_q;
	logic [15:0] pos_q;
	logic [16:0] b_q;
	logic [6:0]  n_q, i_q;
	logic [5:0]  zeros_q;
	logic        phase_q, miss_q;
	logic [32:0] acc_q;
	logic [1:0]  pops_q;
	logic [7:0]  w0_q, w1_q, w2_q;
	logic        done_q;
	rsp_t        rsp_q;

	bit_t        lk;
	logic        accept, is_ue, we;
	logic [6:0]  cnt_clamp;
	logic [16:0] add_amt, pos_sum;
	logic [15:0] pos_add, pos_b, pos_align;
	logic [16:0] align_sum;
	logic [7:0]  byte_v;
	logic [32:0] half;
	logic        unal_align, done_first;
	logic [6:0]  n_start;
	logic [1:0]  state_first;
	logic [15:0] pos_first;
	logic        find_len4, find_len3, find_fail, find_more;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign is_ue  = (op_q == OP_UE) || (op_q == OP_SE);
	assign we     = accept && (cmd.operation == OP_LOAD) && (fill_q < 13'(FILL_LIMIT));
	assign cnt_clamp = ({1'b0, cmd.bit_count} > MAXB) ? MAXB : {1'b0, cmd.bit_count};

	ebr_bit_unit #(.BUFFER_BYTES(BUFFER_BYTES)) u_bit (
		.clk     (clk),
		.we      (we),
		.fill    (fill_q),
		.wr_data (cmd.data_byte),
		.bit_idx (b_q),
		.lookup  (lk)
	);

	// position adder shared by the finishing step
	always_comb begin
		case (op_q)
			OP_READ: add_amt = {10'd0, n_q};
			OP_TE:   add_amt = 17'd1;
			default: add_amt = 17'd8;
		endcase
		pos_sum = {1'b0, pos_q} + add_amt;
		pos_add = pos_sum[16] ? POS_MAX : pos_sum[15:0];
		pos_b   = b_q[16] ? POS_MAX : b_q[15:0];
		// next byte boundary for an unaligned align
		align_sum = {1'b0, pos_q[15:3], 3'd0} + 17'd8;
		pos_align = align_sum[16] ? POS_MAX : align_sum[15:0];
		byte_v  = miss_q ? BYTE_00 : acc_q[7:0];
		half    = {1'b0, acc_q[32:1]};
		// start-code window checks after each byte
		find_len4 = (pops_q == 2'd3) && (w0_q == BYTE_00) && (w1_q == BYTE_00) &&
		            (w2_q == BYTE_00) && (byte_v == BYTE_01);
		find_fail = (pops_q == 2'd3) &&
		            (({3'd0, pos_add[15:3]} + 16'd4 >= {3'd0, fill_q}) ||
		             (pos_add == POS_MAX));
		find_len3 = (pops_q >= 2'd2) && (w1_q == BYTE_00) && (w2_q == BYTE_00) &&
		            (byte_v == BYTE_01);
		find_more = !find_len4 && !find_fail && !find_len3;
	end

	// command decode at accept
	always_comb begin
		unal_align  = (cmd.operation == OP_ALIGN) && (pos_q[2:0] != 3'd0);
		n_start     = cnt_clamp;
		state_first = S_IDLE;
		done_first  = 1'b0;
		unique case (cmd.operation) inside
			OP_PEEK, OP_READ, OP_UE, OP_SE: state_first = S_FETCH;
			OP_TE: begin
				n_start     = 7'd1;
				state_first = S_FETCH;
			end
			OP_FIND: begin
				n_start     = 7'd8;
				state_first = S_FETCH;
			end
			OP_ALIGN: begin
				n_start     = 7'd8;
				state_first = unal_align ? S_IDLE : S_FETCH;
				done_first  = unal_align;
			end
			OP_POS: done_first = 1'b1;
			default: ;
		endcase
		pos_first = unal_align ? pos_align : pos_q;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= cmd.operation;
						b_q     <= {1'b0, pos_q};
						i_q     <= '0;
						acc_q   <= '0;
						miss_q  <= 1'b0;
						zeros_q <= '0;
						phase_q <= 1'b0;
						pops_q  <= '0;
						n_q     <= n_start;
						rsp_q.value             <= '0;
						rsp_q.status            <= ST_OK;
						rsp_q.start_code_length <= 3'd0;
						rsp_q.byte_position     <= pos_first[15:3];
						rsp_q.bit_in_byte       <= pos_first[2:0];
						state_q <= state_first;
						done_q  <= done_first;
						if (we) fill_q <= fill_q + 13'd1;
						else if (cmd.operation == OP_RESTART) fill_q <= '0;
						if (cmd.operation == OP_RESTART) pos_q <= '0;
						else if (unal_align) pos_q <= pos_first;
					end else begin
						done_q <= 1'b0;
					end
				end
				S_FETCH: state_q <= S_BIT;
				S_BIT: begin
					if (!(is_ue && !phase_q) && (i_q == n_q)) begin
						state_q <= S_POST;
					end else if (!lk.present) begin
						if (is_ue) begin
							rsp_q.status <= ST_GOLOMB;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							miss_q  <= 1'b1;
							state_q <= S_POST;
						end
					end else if (is_ue && !phase_q && !lk.bit_val && zeros_q == 6'd31) begin
						// 32 leading zeros
						rsp_q.status <= ST_GOLOMB;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						b_q <= b_q + 17'd1;
						if (b_q[2:0] == 3'd7) state_q <= S_FETCH;
						if (is_ue && !phase_q) begin
							if (lk.bit_val) begin
								acc_q   <= 33'd1;
								phase_q <= 1'b1;
								n_q     <= {1'b0, zeros_q};
							end else begin
								zeros_q <= zeros_q + 6'd1;
							end
						end else begin
							acc_q <= {acc_q[31:0], lk.bit_val};
							i_q   <= i_q + 7'd1;
						end
					end
				end
				S_POST: begin
					if (op_q == OP_FIND && find_more) begin
						// slide the window and fetch the next byte
						if (pops_q != 2'd3) pops_q <= pops_q + 2'd1;
						pos_q <= pos_add;
						rsp_q.byte_position <= pos_add[15:3];
						rsp_q.bit_in_byte   <= pos_add[2:0];
						w0_q    <= w1_q;
						w1_q    <= w2_q;
						w2_q    <= byte_v;
						b_q     <= {1'b0, pos_add};
						i_q     <= '0;
						acc_q   <= '0;
						miss_q  <= 1'b0;
						state_q <= S_FETCH;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						case (op_q)
							OP_PEEK: rsp_q.value <= miss_q ? '0 : acc_q;
							OP_READ: begin
								rsp_q.value <= miss_q ? '0 : acc_q;
								pos_q <= pos_add;
								rsp_q.byte_position <= pos_add[15:3];
								rsp_q.bit_in_byte   <= pos_add[2:0];
							end
							OP_UE, OP_SE: begin
								if (op_q == OP_UE) rsp_q.value <= acc_q - 33'd1;
								else rsp_q.value <= acc_q[0] ? -half : half;
								pos_q <= pos_b;
								rsp_q.byte_position <= pos_b[15:3];
								rsp_q.bit_in_byte   <= pos_b[2:0];
							end
							OP_TE: begin
								rsp_q.value <= {32'd0, miss_q | ~acc_q[0]};
								pos_q <= pos_add;
								rsp_q.byte_position <= pos_add[15:3];
								rsp_q.bit_in_byte   <= pos_add[2:0];
							end
							OP_ALIGN: begin
								if (!miss_q && acc_q[7:0] == BYTE_7F) begin
									pos_q <= pos_add;
									rsp_q.byte_position <= pos_add[15:3];
									rsp_q.bit_in_byte   <= pos_add[2:0];
								end
							end
							OP_FIND: begin
								pos_q <= pos_add;
								rsp_q.byte_position <= pos_add[15:3];
								rsp_q.bit_in_byte   <= pos_add[2:0];
								if (find_len4) rsp_q.start_code_length <= 3'd4;
								else if (find_fail) rsp_q.status <= ST_NOT_FOUND;
								else rsp_q.start_code_length <= 3'd3;
							end
							default: ;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_fill_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 13'(FILL_LIMIT))
		else $error("fill beyond buffer limit");

	a_bit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BIT && !is_ue) |-> (i_q <= n_q))
		else $error("bit counter passed its target");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> ($past(busy) || $past(start)))
		else $error("result without a command");

	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.start_code_length == 3'd0))
		else $error("length reported on failure");

endmodule

### hw/rtl/ebr_bit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebr_bit_unit - byte buffer and single-bit lookup
// Holds the loaded bytes; returns one bit at a bit index plus whether that
// bit lies inside the fill. Read data is registered: the byte of a bit index
// is valid in the cycle after the index first points at it.
// ----------------------------------------------------------------------------
module ebr_bit_unit import ebr_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        we,
	input  logic [12:0] fill,
	input  logic [7:0]  wr_data,
	input  logic [16:0] bit_idx,
	output bit_t        lookup
);

	localparam int AW = $clog2(BUFFER_BYTES);

	logic [7:0]     mem [BUFFER_BYTES];
	logic [7:0]     rd_data_q;
	logic [13:0]    byte_idx;
	logic [AW+13:0] rd_ext;
	logic [AW+12:0] wr_ext;

	assign byte_idx = bit_idx[16:3];
	assign rd_ext   = {{AW{1'b0}}, byte_idx};
	assign wr_ext   = {{AW{1'b0}}, fill};

	// write at the fill, read the byte under the bit index
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_ext[AW-1:0]] <= wr_data;
		end
		rd_data_q <= mem[rd_ext[AW-1:0]];
	end

	assign lookup.present = ({1'b0, fill} > byte_idx);
	assign lookup.bit_val = rd_data_q[3'd7 - bit_idx[2:0]];

endmodule

### sim/ebr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebr_checker - result predictor and scoreboard of the Exp-Golomb bit reader
// Watches the command and result channels. Each command word taken is applied
// to a private copy of the buffer, fill and read position. The expected
// result words wait in order, and each one is compared with the next result
// word the block gives.
// ----------------------------------------------------------------------------
module ebr_checker import ebr_pkg::*; #(
	parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF,
	parameter int MAX_READ_BITS = MAX_READ_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  cmd_t cmd,
	input  logic done,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending
);

	// private copy of the reader state
	logic [7:0] buf_mem [BUFFER_BYTES];
	int         fill;
	int         rd_pos;
	rsp_t       rsp_due [$];
	int         mism;

	function automatic bit has_bit(int b);
		return (b >> 3) < fill;
	endfunction

	function automatic bit bit_of(int b);
		int idx;
		idx = b >> 3;
		if (idx >= BUFFER_BYTES || idx >= fill)
			return 1'b0;
		return buf_mem[idx][7 - (b & 7)];
	endfunction

	function automatic void step_pos(int n);
		int p;
		p = rd_pos + n;
		rd_pos = (p > int'(POS_MAX)) ? int'(POS_MAX) : p;
	endfunction

	// all-or-nothing: any missing bit gives zero
	function automatic logic [63:0] look_bits(int n);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < n; i++) begin
			if (!has_bit(rd_pos + i))
				return '0;
			v = {v[62:0], bit_of(rd_pos + i)};
		end
		return v;
	endfunction

	function automatic logic [31:0] take_bits(int n);
		logic [31:0] v;
		v = look_bits(n);
		step_pos(n);
		return v;
	endfunction

	function automatic bit golomb_code(output logic [63:0] code);
		int          b;
		int          zeros;
		logic [63:0] sfx;
		b = rd_pos;
		zeros = 0;
		sfx = '0;
		code = '0;
		forever begin
			if (!has_bit(b))
				return 1'b0;
			if (bit_of(b)) begin
				b++;
				break;
			end
			zeros++;
			b++;
			if (zeros >= 32)
				return 1'b0;
		end
		for (int j = 0; j < zeros; j++) begin
			if (!has_bit(b))
				return 1'b0;
			sfx = {sfx[62:0], bit_of(b)};
			b++;
		end
		code = ((64'd1 << zeros) - 64'd1) + sfx;
		step_pos(2 * zeros + 1);
		return 1'b1;
	endfunction

	// start-code search; returns status, sets length
	function automatic logic [1:0] hunt_start(output logic [2:0] len);
		logic [31:0] c0, c1, c2, c3;
		c0 = take_bits(8);
		c1 = take_bits(8);
		c2 = take_bits(8);
		len = 3'd0;
		if (c0 == BYTE_00 && c1 == BYTE_00 && c2 == BYTE_01) begin
			len = 3'd3;
			return ST_OK;
		end
		forever begin
			c3 = take_bits(8);
			if (c0 == BYTE_00 && c1 == BYTE_00 && c2 == BYTE_00 && c3 == BYTE_01) begin
				len = 3'd4;
				return ST_OK;
			end
			if ((rd_pos >> 3) + 4 >= fill || rd_pos >= int'(POS_MAX))
				return ST_NOT_FOUND;
			c0 = c1;
			c1 = c2;
			c2 = c3;
			if (c0 == BYTE_00 && c1 == BYTE_00 && c2 == BYTE_01) begin
				len = 3'd3;
				return ST_OK;
			end
		end
	endfunction

	// apply one command word; returns 1 when it gives a result word
	function automatic bit apply_cmd(cmd_t c, output rsp_t r);
		int          cnt;
		logic [63:0] v;
		logic [63:0] code;
		logic [63:0] k;
		longint      s;
		logic [1:0]  st;
		logic [2:0]  len;
		cnt = (c.bit_count > MAX_READ_BITS) ? MAX_READ_BITS : int'(c.bit_count);
		v = '0;
		st = ST_OK;
		len = 3'd0;
		r = '0;
		case (c.operation)
			OP_RESTART: begin
				fill = 0;
				rd_pos = 0;
				return 1'b0;
			end
			OP_LOAD: begin
				if (fill < BUFFER_BYTES && fill < FILL_MAX) begin
					buf_mem[fill] = c.data_byte;
					fill++;
				end
				return 1'b0;
			end
			OP_PEEK: v = look_bits(cnt);
			OP_READ: begin
				v = look_bits(cnt);
				step_pos(cnt);
			end
			OP_UE: begin
				if (golomb_code(code))
					v = code;
				else
					st = ST_GOLOMB;
			end
			OP_SE: begin
				if (golomb_code(code)) begin
					k = code + 64'd1;
					s = k[0] ? -longint'(k >> 1) : longint'(k >> 1);
					v = s;
				end else begin
					st = ST_GOLOMB;
				end
			end
			OP_TE: v = take_bits(1) ? 64'd0 : 64'd1;
			OP_ALIGN: begin
				if ((rd_pos & 7) == 0) begin
					if (look_bits(8) == BYTE_7F)
						step_pos(8);
				end else begin
					step_pos(8 - (rd_pos & 7));
				end
			end
			OP_FIND: st = hunt_start(len);
			OP_POS: ;
			default: return 1'b0;
		endcase
		r.value = v[32:0];
		r.status = st;
		r.start_code_length = len;
		r.byte_position = rd_pos[15:3];
		r.bit_in_byte = rd_pos[2:0];
		return 1'b1;
	endfunction

	assign pending = rsp_due.size();

	// predict on each word taken, compare on each result word
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_w;
		rsp_t new_w;
		if (!arst_n) begin
			fill = 0;
			rd_pos = 0;
			rsp_due.delete();
			fail_count <= 0;
			mism = 0;
		end else begin
			if (done) begin
				if (rsp_due.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("%0t: result word with nothing expected: %p", $realtime, rsp);
				end else begin
					exp_w = rsp_due.pop_front();
					if (rsp.value !== exp_w.value || rsp.status !== exp_w.status ||
					    rsp.start_code_length !== exp_w.start_code_length ||
					    rsp.byte_position !== exp_w.byte_position ||
					    rsp.bit_in_byte !== exp_w.bit_in_byte) begin
						mism++;
						if (mism <= 10)
							$display("%0t: mismatch expected %p actual %p",
								$realtime, exp_w, rsp);
					end
				end
			end
			if (start && !busy) begin
				if (apply_cmd(cmd, new_w))
					rsp_due.push_back(new_w);
			end
			fail_count <= mism;
		end
	end

endmodule

### sim/tb_bitstream_reader_exp_golomb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitstream_reader_exp_golomb - stimulus and verdict for the bit reader
// Directed commands over the edge cases, then random load-and-parse
// sequences under three idle patterns, then a short four-byte start code
// tail. Checking is done by ebr_checker.
// ----------------------------------------------------------------------------
module tb_bitstream_reader_exp_golomb;
	import ebr_pkg::*;

	localparam logic [3:0] OP_SPARE = 4'd10;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	rsp_t rsp;
	int   fail_count;
	int   pending;
	int   idle_pct;

	bitstream_reader_exp_golomb dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	ebr_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// send one word; returns at the edge where it is taken
	task automatic send(logic [3:0] op, logic [7:0] db, logic [5:0] bc);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= '{operation: op, data_byte: db, bit_count: bc};
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 30) return BYTE_00;
		if (r < 45) return BYTE_01;
		if (r < 55) return BYTE_7F;
		if (r < 62) return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [5:0] pick_count();
		if ($urandom_range(9) == 0)
			return 6'($urandom_range(63));
		return 6'($urandom_range(33));
	endfunction

	initial begin
		#20ms;
		$display("** bitstream_reader_exp_golomb: FAILED **");
		$finish;
	end

	initial begin
		int n;
		int sent;
		int wait_cnt;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		idle_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty buffer, extremes, faults
		send(OP_PEEK, 8'h00, 6'd0);
		send(OP_TE, 8'h00, 6'd0);
		send(OP_UE, 8'h00, 6'd0);
		send(OP_RESTART, 8'h00, 6'd0);
		send(OP_LOAD, 8'h80, 6'd0);
		send(OP_LOAD, 8'h00, 6'd0);
		send(OP_LOAD, 8'h00, 6'd0);
		send(OP_LOAD, 8'h01, 6'd0);
		send(OP_LOAD, 8'hFF, 6'd0);
		send(OP_UE, 8'h00, 6'd0);
		send(OP_SE, 8'h00, 6'd0);
		send(OP_READ, 8'h00, 6'd63);
		send(OP_PEEK, 8'h00, 6'd32);
		send(OP_ALIGN, 8'h00, 6'd0);
		send(OP_POS, 8'h00, 6'd0);
		send(OP_SPARE, 8'h00, 6'd0);
		send(4'hF, 8'hFF, 6'h3F);
		// more than 31 leading zeros
		send(OP_RESTART, 8'h00, 6'd0);
		repeat (5) send(OP_LOAD, 8'h00, 6'd0);
		send(OP_UE, 8'h00, 6'd0);
		send(OP_FIND, 8'h00, 6'd0);
		send(OP_LOAD, 8'h7F, 6'd0);
		send(OP_ALIGN, 8'h00, 6'd0);

		// random load-and-parse sequences, three idle patterns
		sent = 0;
		while (sent < 1050) begin
			if (sent < 350)
				idle_pct = 22;
			else if (sent < 700)
				idle_pct = 45;
			else
				idle_pct = 0;
			send(OP_RESTART, 8'h00, 6'd0);
			n = ($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(12);
			repeat (n) send(OP_LOAD, pick_byte(), 6'd0);
			sent += n + 1;
			n = $urandom_range(1, 12);
			repeat (n) begin
				case ($urandom_range(19))
					0: send(4'($urandom_range(OP_SPARE, 4'hF)), 8'($urandom_range(255)),
						6'($urandom_range(63)));
					1: send(OP_LOAD, pick_byte(), 6'($urandom_range(63)));
					2: send(OP_RESTART, 8'($urandom_range(255)), 6'($urandom_range(63)));
					default: send(4'($urandom_range(OP_PEEK, OP_POS)),
						8'($urandom_range(255)), pick_count());
				endcase
			end
			sent += n;
		end

		// four-byte start code after a junk byte, then decode past the fill
		idle_pct = 10;
		send(OP_RESTART, 8'h00, 6'd0);
		send(OP_LOAD, 8'hFF, 6'd0);
		repeat (3) send(OP_LOAD, 8'h00, 6'd0);
		send(OP_LOAD, 8'h01, 6'd0);
		repeat (4) send(OP_LOAD, 8'h00, 6'd0);
		send(OP_FIND, 8'h00, 6'd0);
		send(OP_POS, 8'h00, 6'd0);
		send(OP_UE, 8'h00, 6'd0);
		send(OP_SE, 8'h00, 6'd0);
		send(OP_TE, 8'h00, 6'd0);
		send(OP_ALIGN, 8'h00, 6'd0);
		send(OP_FIND, 8'h00, 6'd0);
		send(OP_PEEK, 8'h00, 6'd32);
		start <= 1'b0;

		// drain
		wait_cnt = 0;
		while (pending != 0 && wait_cnt < 200000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** bitstream_reader_exp_golomb: PASSED **");
		else
			$display("** bitstream_reader_exp_golomb: FAILED **");
		$finish;
	end

endmodule
